### rtl/char_lcd_nibble_sequencer_defines.svh
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LCDNS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcdns same-cycle check failed");

// next-cycle implication, disabled in reset
`define LCDNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcdns next-cycle check failed");

`endif

### rtl/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// types, codes and power-up tables of the lcd nibble sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

  localparam logic [1:0] FUNC_CMD  = 2'd0;
  localparam logic [1:0] FUNC_DATA = 2'd1;
  localparam logic [1:0] FUNC_INIT = 2'd2;

  localparam int          INIT_CMD_COUNT = 9;
  localparam int          STEP_W         = 5;
  localparam int          WAIT_W         = 14;
  localparam int          PULSE_W        = 8;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(2 * INIT_CMD_COUNT - 1);
  localparam logic [PULSE_W-1:0] PULSE_RESET   = 8'd20;

  typedef enum logic [1:0] {
    KIND_CMD,
    KIND_DATA,
    KIND_INIT
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
  } entry_t;

  function automatic logic [7:0] init_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h30;
      4'd2:    c = 8'h30;
      4'd3:    c = 8'h20;
      4'd4:    c = 8'h28;
      4'd5:    c = 8'h08;
      4'd6:    c = 8'h01;
      4'd7:    c = 8'h06;
      4'd8:    c = 8'h0C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [WAIT_W-1:0] init_wait(input logic [3:0] idx);
    logic [WAIT_W-1:0] w;
    case (idx)
      4'd0:    w = 14'd5000;
      4'd1:    w = 14'd5000;
      4'd2:    w = 14'd1000;
      4'd3:    w = 14'd10000;
      4'd4:    w = 14'd10000;
      4'd5:    w = 14'd1000;
      4'd6:    w = 14'd1000;
      4'd7:    w = 14'd2000;
      4'd8:    w = 14'd1000;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/lcdns_front.sv
// ----------------------------------------------------------------------------
// lcdns_front
// request intake: classifies each request and pushes known ones to the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_front (
  input  wire logic            start_i,
  input  wire logic [1:0]      func_i,
  input  wire logic [7:0]      byte_value_i,
  input  wire logic            full_i,
  output logic                 busy_o,
  output logic                 push_o,
  output lcdns_pkg::entry_t    entry_o
);

  logic known;

  always_comb begin
    known            = 1'b1;
    entry_o.kind       = lcdns_pkg::KIND_CMD;
    entry_o.byte_value = byte_value_i;
    case (func_i)
      lcdns_pkg::FUNC_CMD:  entry_o.kind = lcdns_pkg::KIND_CMD;
      lcdns_pkg::FUNC_DATA: entry_o.kind = lcdns_pkg::KIND_DATA;
      lcdns_pkg::FUNC_INIT: entry_o.kind = lcdns_pkg::KIND_INIT;
      default:              known        = 1'b0;
    endcase
  end

  // unknown selectors are taken and dropped
  assign busy_o = full_i;
  assign push_o = start_i & ~full_i & known;

endmodule

`default_nettype wire

### rtl/lcdns_fifo.sv
// ----------------------------------------------------------------------------
// lcdns_fifo
// short request queue between intake and strobe sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_fifo #(
  parameter int Depth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lcdns_pkg::entry_t entry_i,
  input  wire logic              pop_i,
  output logic                   full_o,
  output logic                   valid_o,
  output lcdns_pkg::entry_t      entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  lcdns_pkg::entry_t   mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/lcdns_back.sv
// ----------------------------------------------------------------------------
// lcdns_back
// strobe sequencer: expands queued requests into nibble strobes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 q_valid_i,
  input  wire lcdns_pkg::entry_t                    q_entry_i,
  output logic                                      q_pop_o,
  input  wire logic                                 cfg_write_i,
  input  wire logic [lcdns_pkg::PULSE_W-1:0]        cfg_data_i,
  output logic                                      strobe_o,
  output logic                                      reg_select_o,
  output logic [3:0]                                nibble_o,
  output logic [lcdns_pkg::WAIT_W-1:0]              wait_before_us_o,
  output logic [lcdns_pkg::PULSE_W-1:0]             pulse_us_o,
  output logic                                      last_o
);

  logic                               active_q;
  lcdns_pkg::entry_t                  cur_q;
  logic [lcdns_pkg::STEP_W-1:0]       step_q;
  logic [lcdns_pkg::PULSE_W-1:0]      pulse_q;

  logic                               strobe_q;
  logic                               rs_q, last_q;
  logic [3:0]                         nibble_q;
  logic [lcdns_pkg::WAIT_W-1:0]       wait_q;

  logic                               is_init, step_last, load;
  logic [3:0]                         cmd_idx;
  logic [7:0]                         code;

  assign is_init   = (cur_q.kind == lcdns_pkg::KIND_INIT);
  assign step_last = is_init ? (step_q == lcdns_pkg::INIT_LAST_STEP) : step_q[0];
  assign load      = q_valid_i & (~active_q | step_last);
  assign q_pop_o   = load;
  assign cmd_idx   = step_q[lcdns_pkg::STEP_W-1:1];
  assign code      = is_init ? lcdns_pkg::init_cmd(cmd_idx) : cur_q.byte_value;

  // enable pulse width, zero saturates to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= lcdns_pkg::PULSE_RESET;
    end else if (cfg_write_i) begin
      pulse_q <= (cfg_data_i == '0) ? lcdns_pkg::PULSE_W'(1) : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (load) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (active_q) begin
        if (step_last) begin
          active_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_entry_i;
    end
    if (active_q) begin
      rs_q     <= (cur_q.kind == lcdns_pkg::KIND_DATA);
      nibble_q <= step_q[0] ? code[3:0] : code[7:4];
      wait_q   <= (is_init && !step_q[0]) ? lcdns_pkg::init_wait(cmd_idx) : '0;
      last_q   <= step_last;
    end
  end

  assign strobe_o         = strobe_q;
  assign reg_select_o     = rs_q;
  assign nibble_o         = nibble_q;
  assign wait_before_us_o = wait_q;
  assign pulse_us_o       = pulse_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

### rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// 4-bit character lcd request sequencer: bytes and power-up list to strobes
// ----------------------------------------------------------------------------
// Requests are taken on start_i while busy_o is low, one per cycle, into a
// small queue (QueueDepth entries); busy_o rises only when that queue is full.
// The sequencer behind it emits one nibble strobe per cycle while busy: a
// command or data byte gives two strobes on consecutive cycles, a queued next
// request follows with no gap, and an init request gives 18 strobes on
// consecutive cycles. A request goes through the queue and the sequencer's
// step and strobe registers. Strobes cannot be held off; the receiver must
// take each one in the cycle it is shown. A request with selector 3 is taken
// and produces nothing. The pulse width register is always ready and should
// be written only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer #(
  parameter int QueueDepth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire logic [1:0]   func_i,
  input  wire logic [7:0]   byte_value_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_data_i,
  output logic              strobe_o,
  output logic              reg_select_o,
  output logic [3:0]        nibble_o,
  output logic [13:0]       wait_before_us_o,
  output logic [7:0]        pulse_us_o,
  output logic              last_o
);

  logic              push, full, q_valid, q_pop;
  lcdns_pkg::entry_t push_entry, head_entry;

  assign cfg_ready_o = 1'b1;

  lcdns_front u_front (
    .start_i      (start_i),
    .func_i       (func_i),
    .byte_value_i (byte_value_i),
    .full_i       (full),
    .busy_o       (busy_o),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  lcdns_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  lcdns_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_entry_i        (head_entry),
    .q_pop_o          (q_pop),
    .cfg_write_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .strobe_o         (strobe_o),
    .reg_select_o     (reg_select_o),
    .nibble_o         (nibble_o),
    .wait_before_us_o (wait_before_us_o),
    .pulse_us_o       (pulse_us_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

### rtl/lcdns_checker.sv
// ----------------------------------------------------------------------------
// lcdns_checker
// port-level checks on the strobe stream of the lcd nibble sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_nibble_sequencer_defines.svh"

module lcdns_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         strobe_o,
  input wire logic         reg_select_o,
  input wire logic [13:0]  wait_before_us_o,
  input wire logic [7:0]   pulse_us_o,
  input wire logic         last_o
);

  logic has_wait, data_first;

  assign has_wait   = (wait_before_us_o != 14'd0);
  assign data_first = strobe_o && reg_select_o && !last_o;

  // pulse width never reads zero
  `LCDNS_ASSERT_NOW(a_pulse_nonzero, strobe_o, pulse_us_o != 8'd0)

  // strobes of one request come on consecutive cycles
  `LCDNS_ASSERT_NEXT(a_burst_gapless, strobe_o && !last_o, strobe_o)

  // a data byte is exactly two strobes
  `LCDNS_ASSERT_NEXT(a_data_pair, data_first, strobe_o && reg_select_o && last_o)

  // a wait only precedes an upper nibble, so the next strobe has none
  `LCDNS_ASSERT_NEXT(a_wait_upper_only, strobe_o && has_wait, strobe_o && !has_wait)

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (.*);

`default_nettype wire

### sim/tb_char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer
// self-checking bench for the 4-bit lcd request sequencer
// ----------------------------------------------------------------------------
// Drives command, data, power-up and unused-selector requests with random
// gaps and bursts, and changes the pulse width between phases. A scoreboard
// expands each accepted request into the nibble strobes it must produce and
// checks every strobe, field by field, in order.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer;

  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         DRAIN_CYCLES   = 10;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         MAX_REPORTS    = 10;
  localparam int         RANDOM_PHASES  = 7;
  localparam int         PHASE_ITEMS    = 60;

  localparam logic [7:0] POWER_UP_CMDS [lcdns_pkg::INIT_CMD_COUNT] = '{
    8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
  };
  localparam logic [lcdns_pkg::WAIT_W-1:0] POWER_UP_WAITS [lcdns_pkg::INIT_CMD_COUNT] = '{
    14'd5000, 14'd5000, 14'd1000, 14'd10000, 14'd10000,
    14'd1000, 14'd1000, 14'd2000, 14'd1000
  };

  typedef struct packed {
    logic                          rs;
    logic [3:0]                    nibble;
    logic [lcdns_pkg::WAIT_W-1:0]  wait_us;
    logic [lcdns_pkg::PULSE_W-1:0] pulse;
    logic                          last;
  } strobe_t;

  class lcd_strobe_scoreboard;
    strobe_t                       strobe_q[$];
    logic [lcdns_pkg::PULSE_W-1:0] pulse_width;
    int                            mismatches;

    function new();
      pulse_width = lcdns_pkg::PULSE_RESET;
      mismatches  = 0;
    endfunction

    function void write_pulse(logic [7:0] value);
      pulse_width = (value == 8'd0) ? 8'd1 : value;
    endfunction

    function void push_byte(logic rs, logic [7:0] value,
                            logic [lcdns_pkg::WAIT_W-1:0] wt, logic closes);
      strobe_q.push_back('{rs, value[7:4], wt, pulse_width, 1'b0});
      strobe_q.push_back('{rs, value[3:0], '0, pulse_width, closes});
    endfunction

    function void note_request(logic [1:0] func, logic [7:0] value);
      case (func)
        lcdns_pkg::FUNC_CMD:  push_byte(1'b0, value, '0, 1'b1);
        lcdns_pkg::FUNC_DATA: push_byte(1'b1, value, '0, 1'b1);
        lcdns_pkg::FUNC_INIT: begin
          for (int i = 0; i < lcdns_pkg::INIT_CMD_COUNT; i++)
            push_byte(1'b0, POWER_UP_CMDS[i], POWER_UP_WAITS[i],
                      i == lcdns_pkg::INIT_CMD_COUNT - 1);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return strobe_q.size();
    endfunction

    function void check_strobe(strobe_t got);
      strobe_t want;
      if (strobe_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: strobe with nothing pending: rs=%0b nib=%h wait=%0d pulse=%0d last=%0b",
                   $realtime, got.rs, got.nibble, got.wait_us, got.pulse, got.last);
        return;
      end
      want = strobe_q.pop_front();
      if (got.rs !== want.rs || got.nibble !== want.nibble || got.wait_us !== want.wait_us ||
          got.pulse !== want.pulse || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: strobe mismatch", $realtime);
          $display("  expected rs=%0b nib=%h wait=%0d pulse=%0d last=%0b",
                   want.rs, want.nibble, want.wait_us, want.pulse, want.last);
          $display("  actual   rs=%0b nib=%h wait=%0d pulse=%0d last=%0b",
                   got.rs, got.nibble, got.wait_us, got.pulse, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [7:0]  byte_value_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        strobe_o;
  logic        reg_select_o;
  logic [3:0]  nibble_o;
  logic [13:0] wait_before_us_o;
  logic [7:0]  pulse_us_o;
  logic        last_o;

  lcd_strobe_scoreboard sb;
  int                   idle_cycles;
  logic                 burst_mode;

  char_lcd_nibble_sequencer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .byte_value_i     (byte_value_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .strobe_o         (strobe_o),
    .reg_select_o     (reg_select_o),
    .nibble_o         (nibble_o),
    .wait_before_us_o (wait_before_us_o),
    .pulse_us_o       (pulse_us_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      sb.check_strobe('{reg_select_o, nibble_o, wait_before_us_o, pulse_us_o, last_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // holds start high on return so a back-to-back request needs no re-raise
  task automatic send_request(logic [1:0] func, logic [7:0] value);
    start_i      <= 1'b1;
    func_i       <= func;
    byte_value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(func, value);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_strobes();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pulse_width(logic [7:0] value);
    drain_strobes();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.write_pulse(value);
  endtask

  task automatic send_random_request();
    int         pick;
    logic [1:0] func;
    pick = $urandom_range(0, 99);
    if (pick < 42)      func = lcdns_pkg::FUNC_CMD;
    else if (pick < 84) func = lcdns_pkg::FUNC_DATA;
    else if (pick < 94) func = lcdns_pkg::FUNC_INIT;
    else                func = FUNC_UNUSED;
    send_request(func, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 24) == 0) burst_mode = ~burst_mode;
    if ($urandom_range(0, 39) == 0) drain_strobes();
    else hold_off(burst_mode ? 0 : $urandom_range(0, 13));
  endtask

  initial begin
    logic [7:0] pulse_plan [RANDOM_PHASES];
    sb           = new();
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = lcdns_pkg::FUNC_CMD;
    byte_value_i = 8'h00;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = 8'h00;
    burst_mode   = 1'b0;
    pulse_plan   = '{8'd0, 8'd255, 8'd1, 8'd128, 8'($urandom_range(2, 254)),
                     8'd20, 8'($urandom_range(0, 255))};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset pulse width, field extremes, every selector, back to back
    send_request(lcdns_pkg::FUNC_CMD, 8'h00);
    send_request(lcdns_pkg::FUNC_CMD, 8'hFF);
    send_request(lcdns_pkg::FUNC_DATA, 8'h00);
    send_request(lcdns_pkg::FUNC_DATA, 8'hFF);
    send_request(lcdns_pkg::FUNC_INIT, 8'h00);
    send_request(FUNC_UNUSED, 8'hFF);
    send_request(lcdns_pkg::FUNC_DATA, 8'hA5);
    send_request(FUNC_UNUSED, 8'h00);
    send_request(FUNC_UNUSED, 8'h5A);
    send_request(lcdns_pkg::FUNC_CMD, 8'h5A);
    hold_off(5);
    send_request(lcdns_pkg::FUNC_INIT, 8'hFF);
    send_request(lcdns_pkg::FUNC_INIT, 8'h3C);
    hold_off(13);
    send_request(lcdns_pkg::FUNC_CMD, 8'hF0);
    hold_off(1);
    send_request(lcdns_pkg::FUNC_DATA, 8'h0F);
    hold_off(2);
    send_request(FUNC_UNUSED, 8'hC3);
    send_request(lcdns_pkg::FUNC_DATA, 8'h81);

    // zero width saturates, then the widest setting
    write_pulse_width(8'd0);
    send_request(lcdns_pkg::FUNC_INIT, 8'h00);
    send_request(lcdns_pkg::FUNC_CMD, 8'h01);
    write_pulse_width(8'd255);
    send_request(lcdns_pkg::FUNC_DATA, 8'h7E);
    send_request(lcdns_pkg::FUNC_INIT, 8'hFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_pulse_width(pulse_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end

    drain_strobes();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lcdns_pkg.sv
rtl/lcdns_front.sv
rtl/lcdns_fifo.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_sequencer.sv
rtl/lcdns_checker.sv
sim/tb_char_lcd_nibble_sequencer.sv
